[hw/rtl/mice_pkg.sv]
`default_nettype none

package mice_pkg;

	// Width of one sense snapshot and of the enable register.
	localparam int unsigned SAMPLE_W = 32;

	// Width of the channel index carried by each event.
	localparam int unsigned CHAN_W = 5;

	// Default number of sense channels that may report events.
	localparam int unsigned DEFAULT_CHANNELS = 32;

	// Enable register value after reset: every channel enabled.
	localparam logic [SAMPLE_W-1:0] MASK_RESET = '1;

	// Number of pending samples the queue between front and back can hold.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified sample: the channels that fire and the new levels.
	typedef struct packed {
		logic [SAMPLE_W-1:0] fire;
		logic [SAMPLE_W-1:0] sample;
	} job_t;

	// Status of the event emitter, watched by the top level checks.
	typedef struct packed {
		logic busy;
		logic pend_empty;
	} back_stat_t;

endpackage

`default_nettype wire

[hw/rtl/mice_front.sv]
`default_nettype none

module mice_front #(
	parameter int unsigned CHANNELS = mice_pkg::DEFAULT_CHANNELS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] sample_bits,
	input  wire logic                          q_full,
	output logic                               q_push,
	output mice_pkg::job_t                     q_job
);

	// Only channels below CHANNELS and below the snapshot width can fire.
	localparam int unsigned LANES = (CHANNELS < mice_pkg::SAMPLE_W) ?
		CHANNELS : mice_pkg::SAMPLE_W;
	localparam logic [mice_pkg::SAMPLE_W-1:0] LANE_MASK =
		{mice_pkg::SAMPLE_W{1'b1}} >> (mice_pkg::SAMPLE_W - LANES);

	logic [mice_pkg::SAMPLE_W-1:0] mask_q;
	logic [mice_pkg::SAMPLE_W-1:0] prev_q;
	logic [mice_pkg::SAMPLE_W-1:0] fire;
	logic                          accept;

	// Classify the incoming snapshot against the stored one.
	always_comb begin
		fire     = (sample_bits ^ prev_q) & mask_q & LANE_MASK;
		in_ready = !q_full;
		accept   = in_valid && in_ready;
		q_push   = accept && (|fire);
		q_job.fire   = fire;
		q_job.sample = sample_bits;
	end

	// Enable register and stored snapshot. Every accepted beat replaces the
	// whole snapshot, masked channels included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= mice_pkg::MASK_RESET;
			prev_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				mask_q <= cfg_wr_data;
			end
			if (accept) begin
				prev_q <= sample_bits;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mice_queue.sv]
`default_nettype none

module mice_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mice_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output mice_pkg::job_t      pop_job
);

	localparam int unsigned DEPTH = mice_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	mice_pkg::job_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// Occupancy flags and read side.
	always_comb begin
		full    = (count_q == CNT_W'(DEPTH));
		valid   = (count_q != '0);
		do_push = push && !full;
		do_pop  = pop && valid;
		pop_job = entry_q[rd_ptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mice_back.sv]
`default_nettype none

module mice_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire mice_pkg::job_t              q_job,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mice_pkg::CHAN_W-1:0]      channel,
	output logic                             rising,
	output logic                             last,
	output mice_pkg::back_stat_t             stat
);

	localparam int unsigned W = mice_pkg::SAMPLE_W;

	logic                          busy_q;
	logic [W-1:0]                  pend_q;
	logic [W-1:0]                  smp_q;
	logic                          out_valid_q;
	logic [mice_pkg::CHAN_W-1:0]   channel_q;
	logic                          rising_q;
	logic                          last_q;
	logic [W-1:0]                  low_bit;
	logic [mice_pkg::CHAN_W-1:0]   low_idx;
	logic                          low_last;
	logic                          emit;

	// Lowest pending channel: isolate the bit, then encode it.
	always_comb begin
		low_bit  = pend_q & (~pend_q + 1'b1);
		low_idx  = '0;
		for (int i = 0; i < W; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | mice_pkg::CHAN_W'(i);
			end
		end
		low_last = ((pend_q & ~low_bit) == '0);
		emit     = busy_q && (!out_valid_q || out_ready);
		q_pop    = !busy_q && q_valid;
	end

	// Control: one sample at a time, one event per free output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && low_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending set, sample levels and the output register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pend_q <= q_job.fire;
			smp_q  <= q_job.sample;
		end else if (emit) begin
			pend_q <= pend_q & ~low_bit;
		end
		if (emit) begin
			channel_q <= low_idx;
			rising_q  <= |(smp_q & low_bit);
			last_q    <= low_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign channel         = channel_q;
	assign rising          = rising_q;
	assign last            = last_q;
	assign stat.busy       = busy_q;
	assign stat.pend_empty = (pend_q == '0);

endmodule

`default_nettype wire

[hw/rtl/masked_input_change_event_emitter_core.sv]
// Masked input change event emitter.
// Input channel: in_valid/in_ready with sample_bits, one beat per polled
// snapshot of the sense channels. Output channel: out_valid/out_ready with
// channel, rising and last, one beat per event, in ascending channel order;
// last marks the final event of a snapshot. A snapshot with no enabled change
// produces no beat but still replaces the stored snapshot.
// The front stage classifies a snapshot in the cycle it is accepted and
// places it in a two-entry queue. The emitter takes one snapshot from the
// queue while idle and then sends one event per cycle while the event
// register is free or being taken; the snapshot passes through a queue entry,
// the pending set and the event register before its first event appears.
// in_ready stays high while the queue has room, so the front keeps taking
// snapshots while the emitter works. cfg_wr_en/cfg_wr_data write the enable mask.
// Reset sets the enable mask to all ones, the stored snapshot to zero and
// empties the queue. When the receiver stalls, the event register holds its
// beat, the emitter waits, the queue fills and then in_ready drops.
`default_nettype none

module masked_input_change_event_emitter_core #(
	parameter int unsigned CHANNELS = mice_pkg::DEFAULT_CHANNELS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] sample_bits,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mice_pkg::CHAN_W-1:0]        channel,
	output logic                               rising,
	output logic                               last
);

	logic                 q_full;
	logic                 q_push;
	mice_pkg::job_t       push_job;
	logic                 q_pop;
	logic                 q_valid;
	mice_pkg::job_t       pop_job;
	mice_pkg::back_stat_t back_stat;

	// Front: accept and classify snapshots.
	mice_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_bits(sample_bits),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	// Queue of classified snapshots.
	mice_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.pop_job (pop_job)
	);

	// Back: emit one event per cycle unless the receiver stalls.
	mice_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel  (channel),
		.rising   (rising),
		.last     (last),
		.stat     (back_stat)
	);

	// A busy emitter always has at least one channel left to report.
	assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.busy |-> !back_stat.pend_empty)
		else $error("emitter busy with no pending channel");

	// The front never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	// A new event beat only appears after the emitter was working.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_stat.busy))
		else $error("event beat without active snapshot");

	// Only snapshots with at least one event enter the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (push_job.fire != '0))
		else $error("empty snapshot queued");

endmodule

`default_nettype wire

[verif/mice_event_checker.sv]
`default_nettype none

module mice_event_checker #(
	parameter int unsigned CHANNELS = mice_pkg::DEFAULT_CHANNELS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [mice_pkg::SAMPLE_W-1:0] sample_bits,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [mice_pkg::CHAN_W-1:0]   channel,
	input  wire logic                          rising,
	input  wire logic                          last,
	output int unsigned                        mismatches,
	output int unsigned                        pending,
	output int unsigned                        events_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// One change event as it should appear on the output channel.
	typedef struct packed {
		logic [mice_pkg::CHAN_W-1:0] chan;
		logic                        rise;
		logic                        fin;
	} chg_event_t;

	// Only channels below both the channel count and the sample width report.
	localparam int unsigned ACTIVE_CHANNELS = (CHANNELS < mice_pkg::SAMPLE_W) ?
		CHANNELS : mice_pkg::SAMPLE_W;

	logic [mice_pkg::SAMPLE_W-1:0] enable_mask;
	logic [mice_pkg::SAMPLE_W-1:0] stored_sample;
	chg_event_t                    expected_events[$];

	// Queue the events that one snapshot causes and take it as the new stored snapshot.
	function automatic void predict_events(input logic [mice_pkg::SAMPLE_W-1:0] snap);
		logic [mice_pkg::SAMPLE_W-1:0] fire;
		int                            final_idx;
		chg_event_t                    ev;
		fire = (snap ^ stored_sample) & enable_mask;
		final_idx = -1;
		for (int i = 0; i < ACTIVE_CHANNELS; i++) begin
			if (fire[i]) final_idx = i;
		end
		for (int i = 0; i < ACTIVE_CHANNELS; i++) begin
			if (fire[i]) begin
				ev.chan = mice_pkg::CHAN_W'(i);
				ev.rise = snap[i];
				ev.fin  = (i == final_idx);
				expected_events.push_back(ev);
			end
		end
		stored_sample = snap;
	endfunction

	// Watch both channels and the register port at every edge.
	always @(posedge clk or negedge arst_n) begin
		chg_event_t exp_ev;
		if (!arst_n) begin
			enable_mask = mice_pkg::MASK_RESET;
			stored_sample = '0;
			expected_events.delete();
		end else begin
			// Compare each output beat with the oldest expected event.
			if (out_valid && out_ready) begin
				events_checked++;
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected event: channel %0d rising %0b last %0b",
							$time, channel, rising, last);
				end else begin
					exp_ev = expected_events.pop_front();
					if (exp_ev.chan !== channel || exp_ev.rise !== rising ||
							exp_ev.fin !== last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: event mismatch: expected channel %0d rising %0b ",
								$time, exp_ev.chan, exp_ev.rise);
							$display("last %0b, got channel %0d rising %0b last %0b",
								exp_ev.fin, channel, rising, last);
						end
					end
				end
			end
			// A snapshot beat is classified with the mask in force before any write here.
			if (in_valid && in_ready) predict_events(sample_bits);
			if (cfg_wr_en) enable_mask = cfg_wr_data;
		end
		pending = expected_events.size();
	end

endmodule

`default_nettype wire

[verif/masked_input_change_event_emitter_core_tb.sv]
`default_nettype none

module masked_input_change_event_emitter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_wr_en   = 1'b0;
	logic [mice_pkg::SAMPLE_W-1:0] cfg_wr_data = '0;
	logic                          in_valid    = 1'b0;
	logic [mice_pkg::SAMPLE_W-1:0] sample_bits = '0;
	logic                          out_ready   = 1'b0;
	wire logic                     in_ready;
	wire logic                     out_valid;
	wire logic [mice_pkg::CHAN_W-1:0] channel;
	wire logic                     rising;
	wire logic                     last;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned events_checked;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned samples_sent  = 0;
	int unsigned masks_written = 0;
	logic [mice_pkg::SAMPLE_W-1:0] held_sample = '0;

	masked_input_change_event_emitter_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_bits (sample_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel     (channel),
		.rising      (rising),
		.last        (last)
	);

	mice_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_bits    (sample_bits),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.channel        (channel),
		.rising         (rising),
		.last           (last),
		.mismatches     (mismatches),
		.pending        (pending),
		.events_checked (events_checked)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random with the probability of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one snapshot beat, hold it until accepted, then maybe go idle.
	task automatic send_sample(input logic [mice_pkg::SAMPLE_W-1:0] bits);
		in_valid <= 1'b1;
		sample_bits <= bits;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		held_sample = bits;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			sample_bits <= $urandom();
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Drain every expected event, then idle for a margin with no snapshot offered.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mask(input logic [mice_pkg::SAMPLE_W-1:0] mask);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= $urandom();
		masks_written++;
	endtask

	// Fully random snapshots mixed with sparse changes against the last snapshot, as a real poll sees them.
	function automatic logic [mice_pkg::SAMPLE_W-1:0] next_sample(
			input logic [mice_pkg::SAMPLE_W-1:0] prev);
		logic [mice_pkg::SAMPLE_W-1:0] nxt;
		case ($urandom_range(9))
			0, 1, 2, 3: nxt = $urandom();
			4, 5:       nxt = prev ^ (32'h1 << $urandom_range(31));
			6:          nxt = prev ^ (32'h1 << $urandom_range(31)) ^ (32'h1 << $urandom_range(31));
			7:          nxt = prev ^ ($urandom() & $urandom() & $urandom());
			8:          nxt = prev;
			default:    nxt = $urandom_range(1) ? '1 : '0;
		endcase
		return nxt;
	endfunction

	initial begin
		logic [mice_pkg::SAMPLE_W-1:0] mask;
		int unsigned                   burst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed snapshots with the reset mask: no change, all rising, all falling,
		// both end channels, alternating patterns and a repeat.
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0001);
		send_sample(32'h8000_0000);
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h5555_5555);
		send_sample(32'h5555_5555);
		send_sample(32'h0000_FFFF);

		// Everything masked: snapshots still replace the stored one.
		settle();
		write_mask('0);
		send_sample($urandom());
		send_sample($urandom());
		send_sample($urandom());
		send_sample(32'hFFFF_FFFF);

		// Upper half disabled, then re-enabled: changes seen while disabled stay silent.
		settle();
		write_mask(32'h0000_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_0000);
		settle();
		write_mask('1);
		send_sample(32'hFFFF_0000);
		send_sample(32'h0000_0001);

		// Random segments, each with its own mask and idling phase.
		for (int seg = 0; seg < 8; seg++) begin
			settle();
			case (seg)
				0:       mask = '1;
				1:       mask = $urandom();
				2:       mask = 32'h1 << $urandom_range(31);
				3:       mask = $urandom() & $urandom();
				4:       mask = '0;
				5:       mask = 32'h8000_0001;
				6:       mask = $urandom() | $urandom();
				default: mask = '1;
			endcase
			write_mask(mask);
			case (seg % 4)
				0:       begin send_idle_pct = 0;  stall_pct = 0;  end
				1:       begin send_idle_pct = 69; stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  stall_pct = 69; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			burst = (mask == '0) ? 20 : 60;
			repeat (burst) send_sample(next_sample(held_sample));
		end

		// Wait for the last events, then a margin for anything stray.
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);

		$display("Sent %0d snapshots under %0d enable masks and checked %0d events.",
			samples_sent, masks_written, events_checked);
		$display("Mismatches: %0d, events still outstanding: %0d.", mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Give up well past the slowest correct run.
	initial begin
		#10_000_000;
		$display("Timeout with %0d events outstanding.", pending);
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/mice_pkg.sv
hw/rtl/mice_front.sv
hw/rtl/mice_queue.sv
hw/rtl/mice_back.sv
hw/rtl/masked_input_change_event_emitter_core.sv
verif/mice_event_checker.sv
verif/masked_input_change_event_emitter_core_tb.sv
